/* design/romb_pkg.sv */
// Shared types and constants of the Romberg integrator.
package romb_pkg;

  localparam int MAX_LEVELS_DEF = 10;
  localparam logic [30:0] TOL_RESET = 31'd6711;
  localparam logic [3:0] LIMIT_RESET = 4'd10;

  localparam int CFG_W = 31;
  localparam logic REG_TOLERANCE = 1'b0;
  localparam logic REG_LEVEL_LIMIT = 1'b1;

  localparam int CHUNK = 16;
  localparam logic [5:0] DIV_LAST = 6'd63;
  localparam logic [4:0] MIN_LIMIT = 5'd2;

  typedef enum logic [3:0] {
    ST_IDLE, ST_LVL, ST_POS, ST_SQ, ST_FLOAD, ST_FDIV, ST_FACC, ST_MUL, ST_RND,
    ST_RD0, ST_CUR, ST_RDK, ST_EXK, ST_XDIV, ST_XEND, ST_FIN
  } state_t;

  typedef enum logic {
    PH_ENDS,
    PH_MID
  } phase_t;

endpackage

/* design/romberg_integrator_unit.sv */
// Romberg integrator of 4/(1+x^2): sequencer, shared divider and row memory.
// Usage:
//   Requests carry lower_limit and upper_limit (signed Q16.16) on a valid/ready
//   channel; in_ready is high only while the sequencer is free. Each request
//   gives one result (integral in signed Q6.26, saturated, converged flag,
//   levels_used) on the out channel, held in an output register.
//   cfg_we/cfg_index/cfg_data write tolerance (index 0) or level_limit
//   (index 1); write only while the block is idle.
// Work per request:
//   Every integrand sample and every extrapolation step runs on the same
//   64-step restoring divider. Level L adds 2^(L-1) samples and L
//   extrapolations, so a run that converges early does less work.
//   One request is worked on at a time.
// Reset:
//   rst clears the sequencer and out_valid and loads tolerance 6711
//   and level_limit 10. The row memory needs no clearing.
// Stall:
//   A result waits in the output register while out_ready is low; a new
//   request is accepted meanwhile, and its result waits until the slot frees.
module romberg_integrator_unit #(
  parameter int MAX_LEVELS = romb_pkg::MAX_LEVELS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [31:0]         lower_limit,
  input  logic signed [31:0]         upper_limit,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [31:0]         integral,
  output logic                       converged,
  output logic [3:0]                 levels_used,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [romb_pkg::CFG_W-1:0] cfg_data
);

  localparam int LW = $clog2(MAX_LEVELS + 1);
  localparam int RAW = $clog2(MAX_LEVELS);
  localparam int JW = MAX_LEVELS - 1;
  localparam int MW = 30 + MAX_LEVELS;
  localparam int NCH = (MW + romb_pkg::CHUNK - 1) / romb_pkg::CHUNK;
  localparam int MOPW = NCH * romb_pkg::CHUNK;
  localparam int MCW = $clog2(NCH);
  localparam int AW = 33 + MOPW;

  romb_pkg::state_t state, state_next;
  romb_pkg::phase_t phase;

  logic [30:0] tolerance;
  logic [3:0]  level_limit;

  // row memory
  logic signed [63:0] row_mem [MAX_LEVELS];
  logic signed [63:0] rdata;
  logic [RAW-1:0]     raddr, waddr;
  logic               we;
  logic signed [63:0] wdata;

  // request context
  logic signed [63:0] lo64, dstep;
  logic               neg;
  logic [32:0]        dmag;
  logic [LW-1:0]      limit, level_count, kk;
  logic               end_sel;

  // sampling
  logic signed [63:0] pos;
  logic [JW-1:0]      j, last_j;
  logic signed [31:0] x;
  logic [31:0]        ax;
  logic [63:0]        sq;
  logic [MW-1:0]      msum, msum_new;

  // multiplier
  logic [MOPW-1:0]    mop;
  logic [MCW-1:0]     mcnt;
  logic [AW-1:0]      acc;
  logic [48:0]        pprod;
  logic [5:0]         shamt;
  logic [AW:0]        rnd;
  logic [63:0]        rmag;
  logic signed [63:0] term_w, term;

  // shared divider
  logic [63:0] dden, dquo, drem;
  logic [5:0]  dcnt;
  logic [64:0] dt;
  logic        dge;

  // extrapolation
  logic signed [63:0] cur, prev_diag, diff, gap_s, half_s, nxt;
  logic [63:0]        vmag, gap, dmag_x, wgt, dsq;
  logic               xneg;

  logic [4:0] lim5;
  logic signed [63:0] pos_n;

  assign in_ready = (state == romb_pkg::ST_IDLE);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance <= romb_pkg::TOL_RESET;
      level_limit <= romb_pkg::LIMIT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        romb_pkg::REG_TOLERANCE:   tolerance <= cfg_data;
        romb_pkg::REG_LEVEL_LIMIT: level_limit <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      row_mem[waddr] <= wdata;
    end
    rdata <= row_mem[raddr];
  end

  // datapath helpers
  assign lim5 = {1'b0, level_limit};
  assign last_j = JW'((64'(1) << (level_count - 1'b1)) - 64'(1));
  assign pos_n = pos + (64'sd1 <<< (level_count - 1'b1));
  assign dsq = 64'h1_0000_0000 + sq;
  assign msum_new = msum + MW'(dquo[31:0]);
  assign pprod = dmag * mop[MOPW-1 -: romb_pkg::CHUNK];
  assign shamt = (phase == romb_pkg::PH_ENDS) ? 6'd20 : 6'd19 + 6'(level_count);
  assign rnd = ({1'b0, acc} + ((AW + 1)'(1) << (shamt - 1'b1))) >> shamt;
  assign rmag = rnd[63:0];
  assign term_w = neg ? -$signed(rmag) : $signed(rmag);
  assign vmag = rdata[63] ? 64'(-rdata) : 64'(rdata);
  assign half_s = rdata[63] ? -$signed((vmag + 64'd1) >> 1) : $signed((vmag + 64'd1) >> 1);
  assign diff = cur - rdata;
  assign dmag_x = diff[63] ? 64'(-diff) : 64'(diff);
  assign wgt = (64'(1) << {kk, 1'b0}) - 64'd1;
  assign nxt = xneg ? cur - $signed(dquo) : cur + $signed(dquo);
  assign gap_s = cur - prev_diag;
  assign gap = gap_s[63] ? 64'(-gap_s) : 64'(gap_s);

  // one restoring step
  assign dt = {drem, dquo[63]};
  assign dge = dt >= {1'b0, dden};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= romb_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and memory control
  always_comb begin
    state_next = state;
    we = 1'b0;
    waddr = '0;
    wdata = cur;
    raddr = RAW'(kk - 1'b1);
    case (state)
      romb_pkg::ST_IDLE: begin
        if (in_valid) state_next = romb_pkg::ST_SQ;
      end
      romb_pkg::ST_LVL:   state_next = romb_pkg::ST_POS;
      romb_pkg::ST_POS:   state_next = romb_pkg::ST_SQ;
      romb_pkg::ST_SQ:    state_next = romb_pkg::ST_FLOAD;
      romb_pkg::ST_FLOAD: state_next = romb_pkg::ST_FDIV;
      romb_pkg::ST_FDIV: begin
        if (dcnt == romb_pkg::DIV_LAST) state_next = romb_pkg::ST_FACC;
      end
      romb_pkg::ST_FACC: begin
        if (phase == romb_pkg::PH_ENDS) begin
          state_next = end_sel ? romb_pkg::ST_MUL : romb_pkg::ST_SQ;
        end else begin
          state_next = (j == last_j) ? romb_pkg::ST_MUL : romb_pkg::ST_POS;
        end
      end
      romb_pkg::ST_MUL: begin
        if (mcnt == MCW'(NCH - 1)) state_next = romb_pkg::ST_RND;
      end
      romb_pkg::ST_RND: begin
        if (phase == romb_pkg::PH_ENDS) begin
          we = 1'b1;
          waddr = '0;
          wdata = term_w;
          state_next = romb_pkg::ST_LVL;
        end else begin
          state_next = romb_pkg::ST_RD0;
        end
      end
      romb_pkg::ST_RD0: begin
        raddr = '0;
        state_next = romb_pkg::ST_CUR;
      end
      romb_pkg::ST_CUR: state_next = romb_pkg::ST_RDK;
      romb_pkg::ST_RDK: state_next = romb_pkg::ST_EXK;
      romb_pkg::ST_EXK: begin
        we = 1'b1;
        waddr = RAW'(kk - 1'b1);
        state_next = romb_pkg::ST_XDIV;
      end
      romb_pkg::ST_XDIV: begin
        if (dcnt == romb_pkg::DIV_LAST) state_next = romb_pkg::ST_XEND;
      end
      romb_pkg::ST_XEND: begin
        state_next = (kk == level_count) ? romb_pkg::ST_FIN : romb_pkg::ST_RDK;
      end
      romb_pkg::ST_FIN: begin
        we = 1'b1;
        waddr = RAW'(level_count);
        if (gap >= {33'd0, tolerance} && (level_count + 1'b1) < limit) begin
          state_next = romb_pkg::ST_LVL;
        end else if (!out_valid || out_ready) begin
          state_next = romb_pkg::ST_IDLE;
        end
      end
      default: state_next = romb_pkg::ST_IDLE;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == romb_pkg::ST_FIN && state_next == romb_pkg::ST_IDLE) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == romb_pkg::ST_FIN && state_next == romb_pkg::ST_IDLE) begin
      if (cur > 64'sd2147483647) begin
        integral <= 32'sh7FFF_FFFF;
      end else if (cur < -64'sd2147483648) begin
        integral <= 32'sh8000_0000;
      end else begin
        integral <= cur[31:0];
      end
      converged <= gap < {33'd0, tolerance};
      levels_used <= 4'(level_count + 1'b1);
    end
  end

  assign ax = x[31] ? 32'(-x) : 32'(x);

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      romb_pkg::ST_IDLE: begin
        lo64 <= 64'(lower_limit);
        dstep <= 64'(upper_limit) - 64'(lower_limit);
        neg <= upper_limit < lower_limit;
        dmag <= (upper_limit < lower_limit) ? 33'(64'(lower_limit) - 64'(upper_limit))
                                            : 33'(64'(upper_limit) - 64'(lower_limit));
        if (lim5 < romb_pkg::MIN_LIMIT) begin
          limit <= LW'(romb_pkg::MIN_LIMIT);
        end else if (lim5 > 5'(MAX_LEVELS)) begin
          limit <= LW'(MAX_LEVELS);
        end else begin
          limit <= LW'(lim5);
        end
        x <= lower_limit;
        msum <= '0;
        end_sel <= 1'b0;
        phase <= romb_pkg::PH_ENDS;
      end
      romb_pkg::ST_LVL: begin
        phase <= romb_pkg::PH_MID;
        j <= '0;
        msum <= '0;
        pos <= (lo64 <<< level_count) + dstep;
      end
      romb_pkg::ST_POS: begin
        x <= 32'(pos_n >>> level_count);
      end
      romb_pkg::ST_SQ: begin
        sq <= ax * ax;
      end
      romb_pkg::ST_FLOAD: begin
        dden <= dsq;
        dquo <= 64'h8000_0000_0000_0000 + (dsq >> 1);
        drem <= '0;
        dcnt <= '0;
      end
      romb_pkg::ST_FDIV, romb_pkg::ST_XDIV: begin
        drem <= dge ? 64'(dt - {1'b0, dden}) : dt[63:0];
        dquo <= {dquo[62:0], dge};
        dcnt <= dcnt + 1'b1;
      end
      romb_pkg::ST_FACC: begin
        msum <= msum_new;
        mop <= MOPW'(msum_new);
        acc <= '0;
        mcnt <= '0;
        if (phase == romb_pkg::PH_ENDS) begin
          end_sel <= 1'b1;
          x <= 32'(dstep + lo64);
        end else begin
          j <= j + 1'b1;
          pos <= pos + (dstep <<< 1);
        end
      end
      romb_pkg::ST_MUL: begin
        acc <= (acc << romb_pkg::CHUNK) + AW'(pprod);
        mop <= mop << romb_pkg::CHUNK;
        mcnt <= mcnt + 1'b1;
      end
      romb_pkg::ST_RND: begin
        term <= term_w;
        if (phase == romb_pkg::PH_ENDS) level_count <= LW'(1);
      end
      romb_pkg::ST_CUR: begin
        cur <= half_s + term;
        kk <= LW'(1);
      end
      romb_pkg::ST_EXK: begin
        if (kk == level_count) prev_diag <= rdata;
        xneg <= diff[63];
        dden <= wgt;
        dquo <= dmag_x + (wgt >> 1);
        drem <= '0;
        dcnt <= '0;
      end
      romb_pkg::ST_XEND: begin
        cur <= nxt;
        if (kk != level_count) kk <= kk + 1'b1;
      end
      romb_pkg::ST_FIN: begin
        if (state_next != romb_pkg::ST_FIN) level_count <= level_count + 1'b1;
      end
      default: ;
    endcase
  end

endmodule

/* tb/sv/tb_romberg_integrator_unit.sv */
// Self-checking testbench of the Romberg integrator: directed table, a back-pressure burst, then randomised phases.
`timescale 1ns / 100ps

module tb_romberg_integrator_unit;

  typedef struct {
    logic signed [31:0] integral;
    logic               converged;
    logic [3:0]         levels_used;
  } romb_res_t;

  typedef struct {
    logic signed [31:0] lo;
    logic signed [31:0] hi;
    logic [30:0]        tol;
    logic [3:0]         lim;
    bit                 typed;
    romb_res_t          res;
  } romb_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [31:0] lower_limit = '0;
  logic signed [31:0] upper_limit = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] integral;
  logic converged;
  logic [3:0] levels_used;
  logic cfg_we = 1'b0;
  logic cfg_index = romb_pkg::REG_TOLERANCE;
  logic [romb_pkg::CFG_W-1:0] cfg_data = '0;

  romberg_integrator_unit i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .lower_limit(lower_limit), .upper_limit(upper_limit),
    .out_valid(out_valid), .out_ready(out_ready),
    .integral(integral), .converged(converged), .levels_used(levels_used),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  logic [30:0] tol_cur = romb_pkg::TOL_RESET;
  logic [3:0]  lim_cur = romb_pkg::LIMIT_RESET;
  romb_res_t   pending_q[$];
  int          errors = 0;
  int          n_requests = 0;
  int          n_results = 0;
  int          hold_len = 0;

  task automatic report(string what, longint got, longint want);
    errors++;
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
  endtask

  // ---------------- integral predictor ----------------
  function automatic longint unsigned mag64(longint v);
    return v < 0 ? longint'(0) - v : v;
  endfunction

  function automatic longint signed_of(longint unsigned m, bit neg);
    return neg ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint floor_sh(longint v, int sh);
    if (v >= 0) return v >>> sh;
    return -longint'((mag64(v) + (64'd1 << sh) - 1) >> sh);
  endfunction

  function automatic longint round_sh(longint v, int sh);
    return signed_of((mag64(v) + (64'd1 << (sh - 1))) >> sh, v < 0);
  endfunction

  function automatic longint round_dv(longint num, longint unsigned den);
    return signed_of((mag64(num) + den / 2) / den, num < 0);
  endfunction

  function automatic longint unsigned mul_rnd(longint unsigned a, longint unsigned b, int sh);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    p = p + (128'd1 << (sh - 1));
    p = p >> sh;
    return p[63:0];
  endfunction

  function automatic longint unsigned sample_f(longint x);
    longint unsigned ax, den;
    ax = mag64(x);
    den = (64'd1 << 32) + ax * ax;
    return (64'h8000_0000_0000_0000 + den / 2) / den;
  endfunction

  function automatic romb_res_t predict_integral(logic signed [31:0] lo32,
                                                 logic signed [31:0] hi32);
    longint row[10];
    longint lo, hi, span, cur, nxt, prev, base, pos, outv;
    longint unsigned dmag, msum, gap;
    int limit, lvl, panels;
    bit neg, done;
    romb_res_t r;
    lo = lo32;
    hi = hi32;
    limit = lim_cur;
    if (limit < 2) limit = 2;
    if (limit > 10) limit = 10;
    span = hi - lo;
    neg = span < 0;
    dmag = mag64(span);
    msum = sample_f(lo) + sample_f(hi);
    row[0] = signed_of(mul_rnd(dmag, msum, 20), neg);
    lvl = 1;
    panels = 1;
    done = 0;
    nxt = 0;
    while (!done && lvl < limit) begin
      base = lo * (2 * panels);
      msum = 0;
      for (int j = 0; j < panels; j++) begin
        pos = base + longint'(2 * j + 1) * span;
        msum += sample_f(floor_sh(pos + panels, lvl));
      end
      cur = round_sh(row[0], 1) + signed_of(mul_rnd(dmag, msum, 19 + lvl), neg);
      prev = row[lvl - 1];
      for (int k = 1; k <= lvl; k++) begin
        nxt = cur + round_dv(cur - row[k - 1], (64'd1 << (2 * k)) - 1);
        row[k - 1] = cur;
        cur = nxt;
      end
      gap = mag64(nxt - prev);
      lvl++;
      row[lvl - 1] = nxt;
      panels *= 2;
      if (gap < longint'(tol_cur)) done = 1;
    end
    outv = row[lvl - 1];
    if (outv > 64'sd2147483647) outv = 64'sd2147483647;
    if (outv < -64'sd2147483648) outv = -64'sd2147483648;
    r.integral = outv[31:0];
    r.converged = done;
    r.levels_used = lvl[3:0];
    return r;
  endfunction

  // ---------------- request side ----------------
  task automatic write_reg(logic idx, logic [romb_pkg::CFG_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == romb_pkg::REG_TOLERANCE) tol_cur = val;
    else lim_cur = val[3:0];
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic set_config(logic [30:0] tol, logic [3:0] lim);
    if (tol != tol_cur || lim != lim_cur) begin
      drain();
      if (tol != tol_cur) write_reg(romb_pkg::REG_TOLERANCE, tol);
      if (lim != lim_cur) write_reg(romb_pkg::REG_LEVEL_LIMIT, {27'd0, lim});
    end
  endtask

  task automatic send(logic signed [31:0] lo, logic signed [31:0] hi, bit typed,
                      romb_res_t res, bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 10);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    lower_limit <= lo;
    upper_limit <= hi;
    do @(posedge clk); while (!in_ready);
    pending_q.push_back(typed ? res : predict_integral(lo, hi));
    n_requests++;
  endtask

  function automatic logic signed [31:0] rand_limit();
    int k;
    k = $urandom_range(0, 9);
    if (k == 0) return $urandom;
    if (k < 3) return $signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
    return $signed($urandom_range(0, 32'h0006_0000)) - 32'sh0003_0000;
  endfunction

  // ---------------- result side ----------------
  initial begin
    romb_res_t want;
    int gap;
    @(negedge rst);
    forever begin
      if (hold_len > 0) begin
        out_ready <= 1'b0;
        repeat (hold_len) @(posedge clk);
        hold_len = 0;
      end
      gap = $urandom_range(0, 10);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      n_results++;
      if (pending_q.size() == 0) begin
        report("unexpected result", integral, 0);
      end else begin
        want = pending_q.pop_front();
        if (integral !== want.integral) report("integral", integral, want.integral);
        if (converged !== want.converged) report("converged", converged, want.converged);
        if (levels_used !== want.levels_used)
          report("levels_used", levels_used, want.levels_used);
      end
    end
  end

  initial begin
    #500000000;
    $display("timeout with %0d results outstanding", pending_q.size());
    $display("status: fail");
    $finish;
  end

  // ---------------- stimulus ----------------
  romb_row_t dir_tab[15] = '{
    '{32'sh0, 32'sh0, 31'd6711, 4'd10, 1, '{32'sh0, 1'b1, 4'd2}},
    '{32'sh0, 32'sh0001_0000, 31'd6711, 4'd10, 0, '{0, 0, 0}},
    '{32'sh0001_0000, 32'sh0, 31'd6711, 4'd10, 0, '{0, 0, 0}},
    '{32'sh0005_0000, 32'sh0005_0000, 31'd0, 4'd3, 1, '{32'sh0, 1'b0, 4'd3}},
    '{32'sh0, 32'sh0, 31'd0, 4'd0, 1, '{32'sh0, 1'b0, 4'd2}},
    '{32'sh0, 32'sh0, 31'd0, 4'd1, 1, '{32'sh0, 1'b0, 4'd2}},
    '{-32'sh0001_0000, 32'sh0001_0000, 31'd6711, 4'd15, 0, '{0, 0, 0}},
    '{32'sh8000_0000, 32'sh7FFF_FFFF, 31'h7FFF_FFFF, 4'd2, 1,
      '{32'sh7FFF_FFFF, 1'b0, 4'd2}},
    '{32'sh7FFF_FFFF, 32'sh8000_0000, 31'h7FFF_FFFF, 4'd2, 1,
      '{32'sh8000_0000, 1'b0, 4'd2}},
    '{32'sh8000_0000, 32'sh8000_0000, 31'h7FFF_FFFF, 4'd4, 1, '{32'sh0, 1'b1, 4'd2}},
    '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 31'h7FFF_FFFF, 4'd4, 1, '{32'sh0, 1'b1, 4'd2}},
    '{32'sh0, 32'sh7FFF_FFFF, 31'd6711, 4'd4, 0, '{0, 0, 0}},
    '{32'shFFFF_FFFF, 32'sh1, 31'd1, 4'd5, 0, '{0, 0, 0}},
    '{-32'sh0003_0000, 32'sh0002_8000, 31'd100, 4'd6, 0, '{0, 0, 0}},
    '{32'sh5555_5555, -32'sh5555_5556, 31'h2AAA_AAAA, 4'd3, 0, '{0, 0, 0}}
  };

  initial begin
    romb_res_t none;
    logic [30:0] tol;
    logic [3:0]  lim;
    int n;
    none = '{0, 0, 0};
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_tab[i]) begin
      set_config(dir_tab[i].tol, dir_tab[i].lim);
      send(dir_tab[i].lo, dir_tab[i].hi, dir_tab[i].typed, dir_tab[i].res, 0);
    end

    // receiver held off while requests keep coming, so the block backs up
    set_config(31'd6711, 4'd2);
    hold_len = 3000;
    repeat (5) send(rand_limit(), rand_limit(), 0, none, 1);
    drain();

    for (int ph = 0; ph < 10; ph++) begin
      case ($urandom_range(0, 4))
        0: tol = 31'd0;
        1: tol = 31'h7FFF_FFFF;
        2: tol = 31'($urandom_range(0, 20000));
        3: tol = romb_pkg::TOL_RESET;
        default: tol = 31'($urandom);
      endcase
      lim = (ph == 9) ? 4'd15 : 4'($urandom_range(0, 6));
      n = (ph == 9) ? 3 : 10;
      set_config(tol, lim);
      repeat (n) send(rand_limit(), rand_limit(), 0, none, $urandom_range(0, 3) == 0);
      if (ph == 4) drain();
    end

    drain();
    repeat (100) @(posedge clk);
    $display("covered %0d requests and %0d results over directed and random phases",
             n_requests, n_results);
    $display("tolerance and level limit swept through extremes, with stalls both sides");
    if (errors == 0 && pending_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* files.f */
design/romb_pkg.sv
design/romberg_integrator_unit.sv
tb/sv/tb_romberg_integrator_unit.sv
